// ===== rtl/core/smpx_pkg.sv =====
// Shared constants, types, tables and helper functions of the simplex noise block.
`default_nettype none

package smpx_pkg;

	localparam int unsigned COORD_FRAC_BITS_DEF = 16;
	localparam int unsigned IFRAC = 24;
	localparam int unsigned D_W = 48;
	localparam int unsigned OFF_W = 27;
	localparam int unsigned SQ_W = 2 * OFF_W;
	localparam int unsigned T_W = 24;
	localparam int unsigned DOT_W = OFF_W + 2;
	localparam int unsigned ACC_W = 33;
	localparam int unsigned QDEPTH = 8;

	localparam logic [1:0] MODE_2D = 2'd0;
	localparam logic [1:0] MODE_3D = 2'd1;
	localparam logic [1:0] MODE_4D = 2'd2;

	localparam logic [1:0] GP = 2'b01;
	localparam logic [1:0] GM = 2'b11;
	localparam logic [1:0] GZ = 2'b00;

	localparam logic [D_W-1:0] ONE_Q = D_W'(1) << IFRAC;

	typedef struct packed {
		logic [1:0]            mode;
		logic [3:0][D_W-1:0]   d0;
		logic [3:0][7:0]       cell8;
		logic [4:0][3:0]       bits;
	} smpx_item_t;

	localparam logic [7:0] PERM_ROM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
		8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
		8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
		8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
		8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
		8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
		8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
		8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
		8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
		8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
		8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
		8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
		8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
		8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
		8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
		8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
		8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
		8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
		8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
		8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	localparam logic [1:0] G3_TAB [12][3] = '{
		'{GP, GP, GZ}, '{GM, GP, GZ}, '{GP, GM, GZ}, '{GM, GM, GZ},
		'{GP, GZ, GP}, '{GM, GZ, GP}, '{GP, GZ, GM}, '{GM, GZ, GM},
		'{GZ, GP, GP}, '{GZ, GM, GP}, '{GZ, GP, GM}, '{GZ, GM, GM}
	};

	function automatic logic [2:0] dim_n(input logic [1:0] mode);
		logic [2:0] d;
		unique case (mode)
			MODE_2D: d = 3'd2;
			MODE_3D: d = 3'd3;
			MODE_4D: d = 3'd4;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

	function automatic logic [22:0] skew_k(input logic [1:0] mode);
		logic [22:0] k;
		unique case (mode)
			MODE_2D: k = 23'd6140887;
			MODE_3D: k = 23'd5592405;
			MODE_4D: k = 23'd5184445;
			default: k = 23'd0;
		endcase
		return k;
	endfunction

	function automatic logic [21:0] unskew_k(input logic [1:0] mode);
		logic [21:0] k;
		unique case (mode)
			MODE_2D: k = 22'd3545443;
			MODE_3D: k = 22'd2796203;
			MODE_4D: k = 22'd2318554;
			default: k = 22'd0;
		endcase
		return k;
	endfunction

	function automatic logic [T_W-1:0] radius_k(input logic [1:0] mode);
		logic [T_W-1:0] k;
		unique case (mode)
			MODE_2D: k = 24'd8388608;
			MODE_3D: k = 24'd10066330;
			MODE_4D: k = 24'd10066330;
			default: k = 24'd0;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] out_scale(input logic [1:0] mode);
		logic [6:0] k;
		unique case (mode)
			MODE_2D: k = 7'd70;
			MODE_3D: k = 7'd32;
			MODE_4D: k = 7'd27;
			default: k = 7'd0;
		endcase
		return k;
	endfunction

	// Offset shift of corner c: c times the unskew factor.
	function automatic logic [24:0] corner_shift(input logic [1:0] mode, input logic [2:0] c);
		return 25'(c) * 25'(unskew_k(mode));
	endfunction

	// Gradient component of axis a as a sign code; h is the corner hash.
	function automatic logic [1:0] grad_comp(input logic dim4, input logic [7:0] h,
		input logic [1:0] a);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [7:0]  rem;
		logic [1:0]  zero_at;
		logic [1:0]  pos;
		logic [1:0]  sel;
		logic [1:0]  r;
		prod = 16'(h) * 16'd171;
		quo = prod[15:11];
		rem = h - 8'(quo) * 8'd12;
		zero_at = h[4:3];
		pos = (a < zero_at) ? a : a - 2'd1;
		sel = 2'd2 - pos;
		if (!dim4) begin
			r = (a == 2'd3) ? GZ : G3_TAB[rem[3:0]][a];
		end else if (a == zero_at) begin
			r = GZ;
		end else begin
			r = h[{1'b0, sel}] ? GM : GP;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/smpx_in_if.sv =====
// Request channel carrying a mode and four fixed-point coordinates.
`default_nettype none

interface smpx_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [31:0] coord_w;

	modport source(output valid, mode, coord_x, coord_y, coord_z, coord_w, input ready);
	modport sink(input valid, mode, coord_x, coord_y, coord_z, coord_w, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/smpx_out_if.sv =====
// Result channel carrying one Q1.15 noise sample.
`default_nettype none

interface smpx_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] noise_value;

	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/simplex_noise_2d_3d_4d.sv =====
// Top level of the 2D/3D/4D simplex noise generator.
//
//   channel | direction | payload                                   | accepted when
//   --------+-----------+-------------------------------------------+----------------
//   coords  | sink      | mode, coord_x, coord_y, coord_z, coord_w  | valid && ready
//   noise   | source    | noise_value                               | valid && ready
//
// One request enters per clock while a credit is free, one sample leaves per
// clock while the output is taken; requests pass front, queue and back in order.
// The rate is set by the back pipeline, whose stages all advance whenever the
// output register is empty or being taken.
// Reset clears only the valid bits, queue pointers and count, and the credit counter.
// A stalled output holds the back pipeline; the front keeps accepting until
// every queue slot is spoken for.
`default_nettype none

module simplex_noise_2d_3d_4d #(
	parameter int unsigned COORD_FRAC_BITS = smpx_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smpx_in_if.sink     coords,
	smpx_out_if.source  noise
);
	import smpx_pkg::*;

	// The front runs free; it only takes a request when it holds a queue credit,
	// so the queue never overflows and the front never needs to stall.
	logic       push;
	logic       take;
	logic       avail;
	smpx_item_t front_item;
	smpx_item_t head;

	// Front: skews the coordinates, finds the lattice cell and the first-corner
	// offsets, and classifies the request into its simplex corner order.
	smpx_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coords     (coords),
		.item_taken (take),
		.push       (push),
		.item       (front_item)
	);

	// The queue decouples the free-running front from the stallable back.
	smpx_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (take),
		.head      (head),
		.avail     (avail)
	);

	// Back: hashes every corner to a gradient, evaluates the falloff and the
	// dot product per corner in parallel lanes, then sums, scales and saturates.
	smpx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.avail  (avail),
		.take   (take),
		.noise  (noise)
	);

endmodule

`default_nettype wire

// ===== rtl/core/smpx_front.sv =====
// Front pipeline: skew, lattice cell, first-corner offsets and simplex corner selection.
`default_nettype none

module smpx_front #(
	parameter int unsigned COORD_FRAC_BITS = smpx_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	smpx_in_if.sink             coords,
	input  logic                item_taken,
	output logic                push,
	output smpx_pkg::smpx_item_t item
);
	import smpx_pkg::*;

	localparam int unsigned CELL_W = 35 - COORD_FRAC_BITS;
	localparam int unsigned CSUM_W = CELL_W + 2;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	logic [CNT_W-1:0] used_q;
	logic             accept;
	logic [6:1]       vld_q;

	logic signed [31:0] q_in [4];
	logic signed [33:0] sum_in;

	logic [1:0]         mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic signed [31:0] q_s1 [4];
	logic signed [31:0] q_s2 [4];
	logic signed [31:0] q_s3 [4];
	logic signed [31:0] q_s4 [4];
	logic signed [33:0] sum_s1;
	logic signed [57:0] prod_s2;
	logic signed [CELL_W-1:0] cell_s3 [4];
	logic signed [CELL_W-1:0] cell_s4 [4];
	logic [3:0][7:0]    cell8_s5;
	logic signed [D_W-1:0] t24_s4;
	logic signed [D_W-1:0] d0_s5 [4];
	smpx_item_t         item_s6;

	logic signed [33:0]           s_w;
	logic signed [34:0]           qs_w [4];
	logic signed [CSUM_W-1:0]     csum_w;
	logic signed [CSUM_W+22:0]    t24_w;
	logic signed [22:0]           g_w;
	logic signed [23:0]           f_w;
	logic [2:0]                   dim_in, dim_s3;
	logic [4:0][3:0]              bits_w;
	logic [1:0]                   rank_w [4];

	// Every item in the pipeline or the queue holds a credit.
	assign coords.ready = (used_q < CNT_W'(QDEPTH));
	assign accept = coords.valid && coords.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:1], accept};
			if (accept && !item_taken) begin
				used_q <= used_q + CNT_W'(1);
			end else if (!accept && item_taken) begin
				used_q <= used_q - CNT_W'(1);
			end
		end
	end

	assign q_in[0] = coords.coord_x;
	assign q_in[1] = coords.coord_y;
	assign q_in[2] = coords.coord_z;
	assign q_in[3] = coords.coord_w;
	assign dim_in = dim_n(coords.mode);

	always_comb begin
		sum_in = '0;
		for (int a = 0; a < 4; a++) begin
			if (3'(a) < dim_in) begin
				sum_in = sum_in + 34'(q_in[a]);
			end
		end
	end

	assign f_w = $signed({1'b0, skew_k(mode_s1)});
	assign s_w = prod_s2[57:24];
	assign dim_s3 = dim_n(mode_s3);
	assign g_w = $signed({1'b0, unskew_k(mode_s3)});

	always_comb begin
		for (int a = 0; a < 4; a++) begin
			qs_w[a] = 35'(q_s2[a]) + 35'(s_w);
		end
		csum_w = '0;
		for (int a = 0; a < 4; a++) begin
			if (3'(a) < dim_s3) begin
				csum_w = csum_w + CSUM_W'(cell_s3[a]);
			end
		end
		t24_w = csum_w * g_w;
	end

	// Corner selection: comparisons in 2D and 3D, pairwise ranking in 4D.
	always_comb begin
		bits_w = '0;
		for (int a = 0; a < 4; a++) begin
			rank_w[a] = 2'd0;
		end
		for (int a = 0; a < 3; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if (d0_s5[a] > d0_s5[b]) begin
					rank_w[a] = rank_w[a] + 2'd1;
				end else begin
					rank_w[b] = rank_w[b] + 2'd1;
				end
			end
		end
		unique case (mode_s5)
			MODE_2D: begin
				bits_w[2] = 4'b0011;
				if (d0_s5[0] > d0_s5[1]) begin
					bits_w[1] = 4'b0001;
				end else begin
					bits_w[1] = 4'b0010;
				end
			end
			MODE_3D: begin
				bits_w[3] = 4'b0111;
				if (d0_s5[0] >= d0_s5[1]) begin
					if (d0_s5[1] >= d0_s5[2]) begin
						bits_w[1] = 4'b0001;
						bits_w[2] = 4'b0011;
					end else if (d0_s5[0] >= d0_s5[2]) begin
						bits_w[1] = 4'b0001;
						bits_w[2] = 4'b0101;
					end else begin
						bits_w[1] = 4'b0100;
						bits_w[2] = 4'b0101;
					end
				end else begin
					if (d0_s5[1] < d0_s5[2]) begin
						bits_w[1] = 4'b0100;
						bits_w[2] = 4'b0110;
					end else if (d0_s5[0] < d0_s5[2]) begin
						bits_w[1] = 4'b0010;
						bits_w[2] = 4'b0110;
					end else begin
						bits_w[1] = 4'b0010;
						bits_w[2] = 4'b0011;
					end
				end
			end
			MODE_4D: begin
				bits_w[4] = 4'b1111;
				for (int a = 0; a < 4; a++) begin
					bits_w[1][a] = (rank_w[a] >= 2'd3);
					bits_w[2][a] = (rank_w[a] >= 2'd2);
					bits_w[3][a] = (rank_w[a] >= 2'd1);
				end
			end
			default: begin
				bits_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mode_s1 <= coords.mode;
		sum_s1 <= sum_in;
		mode_s2 <= mode_s1;
		prod_s2 <= sum_s1 * f_w;
		mode_s3 <= mode_s2;
		mode_s4 <= mode_s3;
		t24_s4 <= D_W'(t24_w);
		mode_s5 <= mode_s4;
		for (int a = 0; a < 4; a++) begin
			q_s1[a] <= q_in[a];
			q_s2[a] <= q_s1[a];
			q_s3[a] <= q_s2[a];
			q_s4[a] <= q_s3[a];
			cell_s3[a] <= qs_w[a][34:COORD_FRAC_BITS];
			cell_s4[a] <= cell_s3[a];
			cell8_s5[a] <= cell_s4[a][7:0];
			d0_s5[a] <= (D_W'(q_s4[a]) <<< (IFRAC - COORD_FRAC_BITS))
				- (D_W'(cell_s4[a]) <<< IFRAC) + t24_s4;
		end
		item_s6.mode <= mode_s5;
		item_s6.cell8 <= cell8_s5;
		item_s6.bits <= bits_w;
		for (int a = 0; a < 4; a++) begin
			item_s6.d0[a] <= d0_s5[a];
		end
	end

	assign push = vld_q[6];
	assign item = item_s6;

endmodule

`default_nettype wire

// ===== rtl/core/smpx_queue.sv =====
// Small register queue between the front and back pipelines.
`default_nettype none

module smpx_queue #(
	parameter int unsigned DEPTH = smpx_pkg::QDEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  smpx_pkg::smpx_item_t push_item,
	input  logic                 pop,
	output smpx_pkg::smpx_item_t head,
	output logic                 avail
);
	import smpx_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	smpx_item_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign avail = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/smpx_back.sv =====
// Back pipeline: corner hashing, falloff, gradient dot products, sum and output scaling.
`default_nettype none

module smpx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smpx_pkg::smpx_item_t head,
	input  logic                 avail,
	output logic                 take,
	smpx_out_if.source           noise
);
	import smpx_pkg::*;

	localparam int unsigned NC = 5;
	localparam int unsigned NP_W = T_W + 1 + DOT_W;
	localparam int unsigned SC_W = ACC_W + 8;

	logic        adv;
	logic [9:1]  vld_q;

	logic [1:0]  mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic [3:0][7:0] cell8_s1, cell8_s2, cell8_s3;
	logic [4:0][3:0] bits_s1, bits_s2, bits_s3;
	logic signed [OFF_W-1:0] off_s1 [NC][4];
	logic signed [OFF_W-1:0] off_s2 [NC][4];
	logic signed [OFF_W-1:0] off_s3 [NC][4];
	logic signed [OFF_W-1:0] off_s4 [NC][4];
	logic [NC-1:0] live_s1, live_s2, live_s3, live_s4, live_s5, live_s6;
	logic [7:0]  h_s1 [NC];
	logic [7:0]  h_s2 [NC];
	logic [7:0]  h_s3 [NC];
	logic [7:0]  h_s4 [NC];
	logic [SQ_W-1:0] sqr_s2 [NC][4];
	logic [T_W-1:0]  t_s3 [NC];
	logic [2*T_W-1:0] tt_s4 [NC];
	logic [2*T_W-1:0] t4p_s5 [NC];
	logic signed [DOT_W-1:0] dot_s5 [NC];
	logic signed [NP_W-1:0] np_s6 [NC];
	logic signed [ACC_W-1:0] acc_s7;
	logic signed [SC_W-1:0]  sc_s8;
	logic signed [15:0]      noise_s9;

	logic [2:0]  dim_h, dim_1, dim_2, dim_3, dim_5;
	logic signed [OFF_W-1:0] off_w [NC][4];
	logic [NC-1:0] live_w;
	logic [7:0]  h1_w [NC];
	logic [7:0]  h2_w [NC];
	logic [7:0]  h3_w [NC];
	logic [7:0]  h4_w [NC];
	logic signed [SQ_W-1:0] sq_w [NC][4];
	logic [SQ_W:0]   sqs_w;
	logic [30:0] sh_w;
	logic [T_W-1:0] t_w [NC];
	logic [NC-1:0] neg_w;
	logic [2*T_W-1:0] tt_w [NC];
	logic [2*T_W-1:0] t4p_w [NC];
	logic [T_W-1:0]   t2_w, t4_w;
	logic signed [DOT_W-1:0] dot_w [NC];
	logic signed [NP_W-1:0]  np_w [NC];
	logic signed [ACC_W-1:0] acc_w;
	logic signed [SC_W-1:0]  sc_w;
	logic signed [SC_W-1:0]  rnd_w;
	logic signed [SC_W-10:0] r_w;
	logic signed [15:0]      sat_w;
	logic signed [D_W-1:0]   offf_w;
	logic [D_W-OFF_W:0]      top_w;
	logic [1:0]              gc_w;

	// The whole back pipeline moves together; it holds only when the result waits.
	assign adv = !vld_q[9] || noise.ready;
	assign take = adv && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[8:1], avail};
		end
	end

	assign dim_h = dim_n(head.mode);
	assign dim_1 = dim_n(mode_s1);
	assign dim_2 = dim_n(mode_s2);
	assign dim_3 = dim_n(mode_s3);
	assign dim_5 = dim_n(mode_s5);

	// Corner offsets; an offset beyond four units can only give a negative falloff.
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			live_w[c] = (dim_h != 3'd0) && (3'(c) <= dim_h);
			for (int a = 0; a < 4; a++) begin
				offf_w = $signed(head.d0[a]) - (head.bits[c][a] ? ONE_Q : '0)
					+ D_W'(corner_shift(head.mode, 3'(c)));
				if (3'(a) >= dim_h) begin
					offf_w = '0;
				end
				top_w = offf_w[D_W-1:OFF_W-1];
				if (!((&top_w) || !(|top_w))) begin
					live_w[c] = 1'b0;
				end
				off_w[c][a] = offf_w[OFF_W-1:0];
			end
			h1_w[c] = (dim_h > 3'd3)
				? PERM_ROM[head.cell8[3] + {7'd0, head.bits[c][3]}] : 8'd0;
			h2_w[c] = (dim_1 > 3'd2)
				? PERM_ROM[cell8_s1[2] + {7'd0, bits_s1[c][2]} + h_s1[c]] : h_s1[c];
			h3_w[c] = (dim_2 > 3'd1)
				? PERM_ROM[cell8_s2[1] + {7'd0, bits_s2[c][1]} + h_s2[c]] : h_s2[c];
			h4_w[c] = (dim_3 > 3'd0)
				? PERM_ROM[cell8_s3[0] + {7'd0, bits_s3[c][0]} + h_s3[c]] : h_s3[c];
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			for (int a = 0; a < 4; a++) begin
				sq_w[c][a] = off_s1[c][a] * off_s1[c][a];
			end
		end
	end

	// Falloff t = R - |d|^2 for each corner.
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			sqs_w = '0;
			for (int a = 0; a < 4; a++) begin
				sqs_w = sqs_w + (SQ_W + 1)'(sqr_s2[c][a]);
			end
			sh_w = sqs_w[SQ_W:IFRAC];
			neg_w[c] = (sh_w > 31'(radius_k(mode_s2)));
			t_w[c] = radius_k(mode_s2) - sh_w[T_W-1:0];
			tt_w[c] = t_s3[c] * t_s3[c];
		end
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			t2_w = tt_s4[c][2*T_W-1:IFRAC];
			t4p_w[c] = t2_w * t2_w;
			dot_w[c] = '0;
			for (int a = 0; a < 4; a++) begin
				gc_w = grad_comp(dim_n(mode_s4) == 3'd4, h_s4[c], 2'(a));
				unique case (gc_w)
					GP: dot_w[c] = dot_w[c] + DOT_W'(off_s4[c][a]);
					GM: dot_w[c] = dot_w[c] - DOT_W'(off_s4[c][a]);
					default: dot_w[c] = dot_w[c];
				endcase
			end
			t4_w = t4p_s5[c][2*T_W-1:IFRAC];
			np_w[c] = $signed({1'b0, t4_w}) * dot_s5[c];
		end
	end

	always_comb begin
		acc_w = '0;
		for (int c = 0; c < NC; c++) begin
			if (live_s6[c]) begin
				acc_w = acc_w + ACC_W'($signed(np_s6[c][NP_W-1:IFRAC]));
			end
		end
		sc_w = acc_s7 * $signed({1'b0, out_scale(mode_s7)});
		rnd_w = sc_s8 + SC_W'(256);
		r_w = rnd_w[SC_W-1:9];
		if (r_w > (SC_W - 9)'(32767)) begin
			sat_w = 16'sd32767;
		end else if (r_w < -(SC_W - 9)'(32768)) begin
			sat_w = -16'sd32768;
		end else begin
			sat_w = r_w[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= head.mode;
			cell8_s1 <= head.cell8;
			bits_s1 <= head.bits;
			live_s1 <= live_w;
			mode_s2 <= mode_s1;
			cell8_s2 <= cell8_s1;
			bits_s2 <= bits_s1;
			live_s2 <= live_s1;
			mode_s3 <= mode_s2;
			cell8_s3 <= cell8_s2;
			bits_s3 <= bits_s2;
			live_s3 <= live_s2 & ~neg_w;
			mode_s4 <= mode_s3;
			live_s4 <= live_s3;
			mode_s5 <= mode_s4;
			live_s5 <= live_s4;
			mode_s6 <= mode_s5;
			live_s6 <= live_s5;
			mode_s7 <= mode_s6;
			acc_s7 <= (dim_5 == 3'd0 && mode_s6 == mode_s5) ? acc_w : acc_w;
			sc_s8 <= sc_w;
			noise_s9 <= sat_w;
			for (int c = 0; c < NC; c++) begin
				h_s1[c] <= h1_w[c];
				h_s2[c] <= h2_w[c];
				h_s3[c] <= h3_w[c];
				h_s4[c] <= h4_w[c];
				t_s3[c] <= t_w[c];
				tt_s4[c] <= tt_w[c];
				t4p_s5[c] <= t4p_w[c];
				dot_s5[c] <= dot_w[c];
				np_s6[c] <= np_w[c];
				for (int a = 0; a < 4; a++) begin
					off_s1[c][a] <= off_w[c][a];
					off_s2[c][a] <= off_s1[c][a];
					off_s3[c][a] <= off_s2[c][a];
					off_s4[c][a] <= off_s3[c][a];
					sqr_s2[c][a] <= sq_w[c][a];
				end
			end
		end
	end

	assign noise.valid = vld_q[9];
	assign noise.noise_value = noise_s9;

endmodule

`default_nettype wire
